>>> rtl/iscs_pkg.sv
// Shared types, constants and a helper function for the image sensor sequencer.
`default_nettype none

package iscs_pkg;

   localparam int SENSOR_REGS = 8;
   localparam int ADDR_BITS   = 3;
   localparam int IDX_W       = 3;
   localparam int POS_W       = 4;
   localparam int PADDR_W     = 5;
   localparam int CSR_W       = 32;

   localparam logic [31:0] REGS_LO_RESET = 32'h8003_0030;
   localparam logic [31:0] REGS_HI_RESET = 32'h0100_0121;
   localparam logic [7:0]  MARK_SEND_START_RESET = 8'h02;
   localparam logic [7:0]  MARK_START_READ_RESET = 8'h04;
   localparam logic [7:0]  MARK_STOP_READ_RESET  = 8'h00;
   localparam logic [7:0]  PIXEL_FORCE = 8'h01;

   // Command codes carried in the kind field.
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_LOAD    = 2'd1;
   localparam logic [1:0] KIND_CAPTURE = 2'd2;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [2:0] REG_SETTINGS_LO     = 3'd0;
   localparam logic [2:0] REG_SETTINGS_HI     = 3'd1;
   localparam logic [2:0] REG_PIXEL_MODE      = 3'd2;
   localparam logic [2:0] REG_MARK_SEND_START = 3'd3;
   localparam logic [2:0] REG_MARK_START_READ = 3'd4;
   localparam logic [2:0] REG_MARK_STOP_READ  = 3'd5;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_SHIFT = 5'b00010,
      PH_WAIT  = 5'b00100,
      PH_READ  = 5'b01000,
      PH_RESET = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       read_level;
      logic [7:0] pixel_sample;
   } req_type;

   typedef struct packed {
      logic       serial_in_bit;
      logic       load_strobe;
      logic       start_strobe;
      logic       reset_active;
      logic       led_on;
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [31:0] settings_lo;
      logic [31:0] settings_hi;
      logic        pixel_mode;
      logic [7:0]  marker_send_start;
      logic [7:0]  marker_start_read;
      logic [7:0]  marker_stop_read;
   } cfg_type;

   // Sensor registers 0-3 sit in the lo word and 4-7 in the hi word, lowest index in the top byte.
   function automatic logic [7:0] sensor_byte(input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [IDX_W-1:0] idx);
      logic [31:0] word;
      logic [7:0]  sel;
      word = idx[2] ? hi : lo;
      case (idx[1:0])
         2'd0:    sel = word[31:24];
         2'd1:    sel = word[23:16];
         2'd2:    sel = word[15:8];
         default: sel = word[7:0];
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

>>> rtl/iscs_csr.sv
// Configuration register file with an APB-style write and read port.
`default_nettype none

module iscs_csr
   import iscs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]   pwdata,
   output logic      [CSR_W-1:0]   prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[PADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SETTINGS_LO:     cfg_in.settings_lo       = pwdata;
            REG_SETTINGS_HI:     cfg_in.settings_hi       = pwdata;
            REG_PIXEL_MODE:      cfg_in.pixel_mode        = pwdata[0];
            REG_MARK_SEND_START: cfg_in.marker_send_start = pwdata[7:0];
            REG_MARK_START_READ: cfg_in.marker_start_read = pwdata[7:0];
            REG_MARK_STOP_READ:  cfg_in.marker_stop_read  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SETTINGS_LO:     prdata = cfg_ff.settings_lo;
         REG_SETTINGS_HI:     prdata = cfg_ff.settings_hi;
         REG_PIXEL_MODE:      prdata = {31'd0, cfg_ff.pixel_mode};
         REG_MARK_SEND_START: prdata = {24'd0, cfg_ff.marker_send_start};
         REG_MARK_START_READ: prdata = {24'd0, cfg_ff.marker_start_read};
         REG_MARK_STOP_READ:  prdata = {24'd0, cfg_ff.marker_stop_read};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settings_lo       <= REGS_LO_RESET;
         cfg_ff.settings_hi       <= REGS_HI_RESET;
         cfg_ff.pixel_mode        <= 1'b0;
         cfg_ff.marker_send_start <= MARK_SEND_START_RESET;
         cfg_ff.marker_start_read <= MARK_START_READ_RESET;
         cfg_ff.marker_stop_read  <= MARK_STOP_READ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/iscs_core.sv
// Sequencer state machine: computes one result per item and advances the sequence state.
`default_nettype none

module iscs_core
   import iscs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    take,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             led_ff, led_in;

   logic [POS_W-1:0] addr_shift;
   logic [IDX_W-1:0] addr_word;
   logic [POS_W-1:0] data_k;
   logic [2:0]       data_bit;
   logic [7:0]       cur_byte;
   logic             last_reg;

   assign addr_shift = POS_W'(ADDR_BITS - 1) - pos_ff;
   assign addr_word  = idx_ff >> addr_shift;
   assign data_k     = pos_ff - POS_W'(ADDR_BITS);
   assign data_bit   = (data_k > POS_W'(7)) ? 3'd7 : data_k[2:0];
   assign cur_byte   = sensor_byte(cfg.settings_lo, cfg.settings_hi, idx_ff);
   assign last_reg   = (32'(idx_ff) + 32'd1) >= 32'(SENSOR_REGS);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      led_in   = led_ff;
      result   = '0;
      result.busy_res = 1'b1;
      unique case (phase_ff)
         PH_SHIFT: begin
            if (pos_ff < POS_W'(ADDR_BITS)) begin
               // Address bits above the index width go out as zero.
               result.serial_in_bit = (addr_shift < POS_W'(IDX_W)) ? addr_word[0] : 1'b0;
            end else begin
               result.serial_in_bit = cur_byte[3'd7 - data_bit];
               result.load_strobe   = (data_bit == 3'd7);
            end
            if (result.load_strobe) begin
               pos_in = '0;
               if (last_reg) begin
                  idx_in   = '0;
                  phase_in = PH_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         PH_WAIT: begin
            if (req.read_level) begin
               result.byte_valid = 1'b1;
               result.out_byte   = cfg.marker_start_read;
               led_in            = 1'b1;
               phase_in          = PH_READ;
            end
         end
         PH_READ: begin
            if (req.read_level) begin
               if (!cfg.pixel_mode) begin
                  result.byte_valid = 1'b1;
                  result.out_byte   = req.pixel_sample | PIXEL_FORCE;
               end
            end else begin
               result.byte_valid = 1'b1;
               result.out_byte   = cfg.marker_stop_read;
               led_in            = 1'b0;
               phase_in          = PH_RESET;
            end
         end
         PH_RESET: begin
            result.reset_active = 1'b1;
            phase_in            = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            case (req.kind)
               KIND_LOAD: begin
                  result.reset_active = 1'b1;
                  idx_in   = '0;
                  pos_in   = '0;
                  phase_in = PH_SHIFT;
               end
               KIND_CAPTURE: begin
                  result.start_strobe = 1'b1;
                  result.byte_valid   = 1'b1;
                  result.out_byte     = cfg.marker_send_start;
                  phase_in            = PH_WAIT;
               end
               default: result.busy_res = 1'b0;
            endcase
         end
      endcase
      // The indicator reflects its level at the end of this period.
      result.led_on = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         pos_ff   <= '0;
         led_ff   <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         led_ff   <= led_in;
      end
   end

`ifndef SYNTHESIS
   a_led_only_reading: assert property (@(posedge clock) disable iff (reset)
      led_ff == (phase_ff == PH_READ))
      else $error("reading indicator out of step with read phase");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(ADDR_BITS + 7))
      else $error("bit position ran past the last data bit");

   a_last_strobe_idles: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_SHIFT && result.load_strobe && last_reg
      |=> phase_ff == PH_IDLE && idx_ff == '0)
      else $error("load sequence did not end after the last register");

   a_hold_without_take: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff) && $stable(idx_ff) && $stable(pos_ff))
      else $error("sequence state moved without an item");
`endif

endmodule

`default_nettype wire

>>> rtl/image_sensor_load_and_capture_sequencer.sv
// Top level of the image sensor load and capture sequencer.
//
// Each item on the req_ channel stands for one sensor clock period and carries a
// command (tick, load, capture), the sampled READ level and a pixel sample. Every
// accepted item yields exactly one result item on the rsp_ channel with the pins to
// drive to the sensor, an optional output byte and the busy flag.
// The result is registered and offered in the cycle after the item is accepted.
// Throughput is one item per cycle while results are taken, set by the single
// result register, which is refilled in the same cycle that its contents are taken.
// When the receiver stalls, req_ready drops until the held result is taken; no
// state advances meanwhile. Commands that arrive while a sequence runs are ignored.
// The user writes the configuration registers over the APB-style port only while
// idle; the block does not enforce it. Synchronous reset returns the sequencer to
// idle, empties the result register, sets the configuration registers to defaults.
`default_nettype none

module image_sensor_load_and_capture_sequencer
   import iscs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]   pwdata,
   output logic      [CSR_W-1:0]   prdata,
   output logic                    pready
);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    take;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign take         = req_valid && req_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   iscs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   iscs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_data),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !take)
      else $error("item accepted while the result register was blocked");

   a_idle_drains: assert property (@(posedge clock) disable iff (reset)
      !take && rsp_ready |=> !rsp_valid_ff)
      else $error("result register refilled without an item");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the image sensor load and capture sequencer.
`default_nettype none

module tb
   import iscs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_PERIODS = 1250;
   localparam int CYCLE_LIMIT = 400000;

   // Tracks the sequencer's state and settings and predicts the pins for every period.
   class sensor_pin_tracker;
      logic [31:0] regs_lo;
      logic [31:0] regs_hi;
      logic        pix_mode;
      logic [7:0]  mark_send;
      logic [7:0]  mark_read;
      logic [7:0]  mark_stop;
      phase_type   phase;
      logic [2:0]  reg_idx;
      logic [3:0]  bit_pos;
      logic        led;
      rsp_type     pins_due[$];
      int          errors;

      function new();
         regs_lo   = REGS_LO_RESET;
         regs_hi   = REGS_HI_RESET;
         pix_mode  = 1'b0;
         mark_send = MARK_SEND_START_RESET;
         mark_read = MARK_START_READ_RESET;
         mark_stop = MARK_STOP_READ_RESET;
         phase     = PH_IDLE;
         reg_idx   = '0;
         bit_pos   = '0;
         led       = 1'b0;
         errors    = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_SETTINGS_LO:     regs_lo = value;
            REG_SETTINGS_HI:     regs_hi = value;
            REG_PIXEL_MODE:      pix_mode = value[0];
            REG_MARK_SEND_START: mark_send = value[7:0];
            REG_MARK_START_READ: mark_read = value[7:0];
            REG_MARK_STOP_READ:  mark_stop = value[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pins_due.size();
      endfunction

      function void note_period(req_type r);
         rsp_type     e;
         logic [31:0] word;
         int          k;
         e = '0;
         e.busy_res = 1'b1;
         case (phase)
            PH_SHIFT: begin
               if (bit_pos < ADDR_BITS) begin
                  e.serial_in_bit = reg_idx[ADDR_BITS - 1 - bit_pos];
               end else begin
                  k = bit_pos - ADDR_BITS;
                  if (k > 7) k = 7;
                  word = reg_idx[2] ? regs_hi : regs_lo;
                  word = word >> (8 * (3 - reg_idx[1:0]));
                  e.serial_in_bit = word[7 - k];
                  e.load_strobe = (k == 7);
               end
               if (e.load_strobe) begin
                  bit_pos = '0;
                  if (int'(reg_idx) + 1 >= SENSOR_REGS) begin
                     reg_idx = '0;
                     phase = PH_IDLE;
                  end else begin
                     reg_idx = reg_idx + 1'b1;
                  end
               end else begin
                  bit_pos = bit_pos + 1'b1;
               end
            end
            PH_WAIT: begin
               if (r.read_level) begin
                  e.byte_valid = 1'b1;
                  e.out_byte = mark_read;
                  led = 1'b1;
                  phase = PH_READ;
               end
            end
            PH_READ: begin
               if (r.read_level) begin
                  if (!pix_mode) begin
                     e.byte_valid = 1'b1;
                     e.out_byte = r.pixel_sample | PIXEL_FORCE;
                  end
               end else begin
                  e.byte_valid = 1'b1;
                  e.out_byte = mark_stop;
                  led = 1'b0;
                  phase = PH_RESET;
               end
            end
            PH_RESET: begin
               e.reset_active = 1'b1;
               phase = PH_IDLE;
            end
            default: begin
               phase = PH_IDLE;
               if (r.kind == KIND_LOAD) begin
                  e.reset_active = 1'b1;
                  reg_idx = '0;
                  bit_pos = '0;
                  phase = PH_SHIFT;
               end else if (r.kind == KIND_CAPTURE) begin
                  e.start_strobe = 1'b1;
                  e.byte_valid = 1'b1;
                  e.out_byte = mark_send;
                  phase = PH_WAIT;
               end else begin
                  e.busy_res = 1'b0;
               end
            end
         endcase
         e.led_on = led;
         pins_due.push_back(e);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_pins(rsp_type got);
         rsp_type want;
         if (pins_due.size() == 0) begin
            $error("result item 0x%0h arrived with no item outstanding", got);
            errors++;
            return;
         end
         want = pins_due.pop_front();
         compare("serial_in_bit", want.serial_in_bit, got.serial_in_bit);
         compare("load_strobe", want.load_strobe, got.load_strobe);
         compare("start_strobe", want.start_strobe, got.start_strobe);
         compare("reset_active", want.reset_active, got.reset_active);
         compare("led_on", want.led_on, got.led_on);
         compare("byte_valid", want.byte_valid, got.byte_valid);
         compare("out_byte", want.out_byte, got.out_byte);
         compare("busy_res", want.busy_res, got.busy_res);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [PADDR_W-1:0]   paddr = '0;
   logic [CSR_W-1:0]     pwdata = '0;
   logic [CSR_W-1:0]     prdata;
   logic                 pready;

   sensor_pin_tracker tracker = new();
   int  periods_sent = 0;
   int  cycle_count = 0;
   bit  sender_gaps = 1'b0;
   bit  receiver_gaps = 1'b0;

   image_sensor_load_and_capture_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int draw_gap(bit enabled);
      return enabled ? int'($urandom_range(0, 13)) : 0;
   endfunction

   function automatic req_type random_period();
      req_type r;
      r.kind = 2'($urandom_range(0, 3));
      r.read_level = 1'($urandom_range(0, 1));
      r.pixel_sample = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Returns at the edge where the item is taken; valid stays up for a back-to-back item.
   task automatic send_period(req_type r);
      int gap;
      gap = draw_gap(sender_gaps);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      tracker.note_period(r);
      periods_sent++;
   endtask

   task automatic send_fields(logic [1:0] kind, logic read_level, logic [7:0] pixel);
      req_type r;
      r.kind = kind;
      r.read_level = read_level;
      r.pixel_sample = pixel;
      send_period(r);
   endtask

   // Runs out whatever sequence is in progress, with stray commands mixed in.
   task automatic finish_sequence();
      req_type r;
      while (tracker.phase != PH_IDLE) begin
         r = random_period();
         if (tracker.phase == PH_WAIT) r.read_level = 1'b1;
         else if (tracker.phase == PH_READ) r.read_level = 1'b0;
         send_period(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      finish_sequence();
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.write_reg(idx, value);
   endtask

   task automatic write_all(logic [31:0] lo, logic [31:0] hi, logic mode,
                            logic [7:0] m_send, logic [7:0] m_read, logic [7:0] m_stop);
      write_reg(REG_SETTINGS_LO, lo);
      write_reg(REG_SETTINGS_HI, hi);
      write_reg(REG_PIXEL_MODE, {31'd0, mode});
      write_reg(REG_MARK_SEND_START, {24'd0, m_send});
      write_reg(REG_MARK_START_READ, {24'd0, m_read});
      write_reg(REG_MARK_STOP_READ, {24'd0, m_stop});
   endtask

   task automatic run_load();
      finish_sequence();
      send_fields(KIND_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      finish_sequence();
   endtask

   // When a capture has two or more pixels, the first two are the extremes of the sample range.
   task automatic run_capture(int waits, int pixels);
      req_type r;
      finish_sequence();
      send_fields(KIND_CAPTURE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      repeat (waits) begin
         r = random_period();
         r.read_level = 1'b0;
         send_period(r);
      end
      r = random_period();
      r.read_level = 1'b1;
      send_period(r);
      for (int i = 0; i < pixels; i++) begin
         r = random_period();
         r.read_level = 1'b1;
         if (i == 0) r.pixel_sample = 8'h00;
         else if (i == 1) r.pixel_sample = 8'hFF;
         send_period(r);
      end
      r = random_period();
      r.read_level = 1'b0;
      send_period(r);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: when receiver_gaps is set, stalls a random number of cycles before each result item.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(receiver_gaps);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_pins(rsp_data);
      end
   end

   initial begin
      int first_random;
      int pick;
      int settle;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Ticks in idle, including the unused command code.
      send_fields(KIND_SPARE, 1'b1, 8'hFF);
      send_fields(KIND_TICK, 1'b0, 8'h00);
      run_load();
      run_capture(2, 3);
      // A capture command during the closing reset period is ignored.
      send_fields(KIND_CAPTURE, 1'b0, 8'h00);
      send_fields(KIND_TICK, 1'b0, 8'h00);

      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      write_all(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 8'hFF, 8'h00, 8'hFF);
      run_load();
      run_capture(0, 3);
      write_all(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'hFF, 8'h00);
      run_load();
      run_capture(1, 2);
      write_all(REGS_LO_RESET, REGS_HI_RESET, 1'b0, MARK_SEND_START_RESET,
                MARK_START_READ_RESET, MARK_STOP_READ_RESET);

      first_random = periods_sent;
      while (periods_sent - first_random < RANDOM_PERIODS) begin
         sender_gaps = $urandom_range(0, 9) < 6;
         receiver_gaps = $urandom_range(0, 9) < 6;
         if ($urandom_range(0, 5) == 0) write_reg(3'($urandom_range(0, 5)), pick_value());
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            run_load();
         end else if (pick < 70) begin
            run_capture($urandom_range(0, 5), $urandom_range(0, 30));
         end else begin
            repeat ($urandom_range(1, 10)) send_period(random_period());
         end
      end

      req_valid <= 1'b0;
      settle = 0;
      while (tracker.pending() != 0 && settle < 10000) begin
         @(posedge clock);
         settle++;
      end
      repeat (4) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         if (tracker.pending() != 0)
            $error("%0d result items never arrived", tracker.pending());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> image_sensor_load_and_capture_sequencer.f
rtl/iscs_pkg.sv
rtl/iscs_csr.sv
rtl/iscs_core.sv
rtl/image_sensor_load_and_capture_sequencer.sv
tb/sv/tb.sv
